/* hw/rtl/alt_pkg.sv */
// alt_pkg: shared types, register codes and constants of the antialiased line tessellator
// depends on nothing; used by every module under hw/rtl
package alt_pkg;

    localparam int CFG_ADDR_W  = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int NUM_RESULTS = 18;
    localparam int NUM_VERTS   = 8;
    localparam int DIV_STEPS   = 33;
    localparam int ROOT_STEPS  = 32;

    localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_BORDER_WIDTH = 2'd1;
    localparam logic [1:0] REG_FILL_COLOR   = 2'd2;

    localparam logic [30:0] LINE_WIDTH_RST   = 31'd65536;
    localparam logic [30:0] BORDER_WIDTH_RST = 31'd65536;
    localparam logic [31:0] FILL_COLOR_RST   = 32'hFFFF_FFFF;

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    localparam logic [30:0]        R_MIN       = 31'd655;
    localparam logic signed [32:0] R_LOW_LIMIT = 33'sd1310;
    localparam logic signed [32:0] WIDTH_ONE   = 33'sd65536;
    localparam logic [63:0] MAG_THRESH = 64'd4611686018427;
    localparam logic [63:0] CAP_THRESH = 64'd461168601842738790;
    localparam logic [31:0] SCALE_ONE  = 32'h1000_0000;
    localparam logic [31:0] SCALE_CAP  = 32'hA000_0000;
    localparam logic signed [39:0] MX_LIMIT = 40'sd4294967296;

    // one segment as it sits in the queue
    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic        [31:0] vertex_base;
        logic signed [32:0] d_x;
        logic signed [32:0] d_y;
    } seg_t;

    // finished vertex set handed to the emitter
    typedef struct packed {
        logic [7:0][31:0] vert_x;
        logic [7:0][31:0] vert_y;
        logic [31:0]      color;
        logic [31:0]      base;
    } vset_t;

    typedef enum logic [2:0] {
        U_IDLE, U_NORM, U_SQ, U_SUM, U_ROOT, U_DIVGO, U_DIVWAIT, U_DONE
    } uvec_state_t;

    typedef enum logic [4:0] {
        E_IDLE, E_DIR, E_RX, E_RY, E_DYS, E_PTS, E_EDGES, E_EDGE_GO, E_EDGE_WAIT,
        E_F_PREP, E_F_SQX, E_F_SQY, E_F_S, E_F_CLASS, E_F_DIV, E_F_MX, E_F_MY,
        E_F_OX, E_F_OY, E_F_ST, E_HAND
    } eng_state_t;

endpackage

/* hw/rtl/alt_front.sv */
// alt_front: input unpacking, segment difference and the segment queue
// depends on alt_pkg
module alt_front #(
    parameter int DEPTH = alt_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [159:0]  s_tdata,
    output logic          q_valid,
    input  logic          q_ready,
    output alt_pkg::seg_t q_seg
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    alt_pkg::seg_t in_seg;
    alt_pkg::seg_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic push, pop;

    always_comb begin
        in_seg.a_x         = s_tdata[31:0];
        in_seg.a_y         = s_tdata[63:32];
        in_seg.b_x         = s_tdata[95:64];
        in_seg.b_y         = s_tdata[127:96];
        in_seg.vertex_base = s_tdata[159:128];
        in_seg.d_x = {s_tdata[95], s_tdata[95:64]} - {s_tdata[31], s_tdata[31:0]};
        in_seg.d_y = {s_tdata[127], s_tdata[127:96]} - {s_tdata[63], s_tdata[63:32]};
    end

    assign s_tready = (count_reg != CNT_W'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_seg    = mem[rd_ptr_reg];
    assign push     = s_tvalid & s_tready;
    assign pop      = q_valid & q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_seg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

/* hw/rtl/alt_div.sv */
// alt_div: restoring divider, one quotient bit per cycle, 33-bit quotient
// depends on alt_pkg
module alt_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [34:0] den,
    output logic        done,
    output logic [32:0] quo
);
    logic [34:0] rem_reg, den_reg;
    logic [32:0] lo_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg, done_reg;
    logic [35:0] trial, diff;
    logic        ge;

    assign trial = {rem_reg, lo_reg[32]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};
    assign done  = done_reg;
    assign quo   = lo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {4'b0, num[63:33]};
            lo_reg  <= num[32:0];
            den_reg <= den;
        end else if (run_reg) begin
            rem_reg <= ge ? diff[34:0] : trial[34:0];
            lo_reg  <= {lo_reg[31:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'(alt_pkg::DIV_STEPS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

/* hw/rtl/alt_uvec.sv */
// alt_uvec: unit vector in Q2.30 from a difference vector (normalize, square root, divide)
// depends on alt_pkg and alt_div
module alt_uvec (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [35:0] in_x,
    input  logic signed [35:0] in_y,
    output logic               done,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y
);
    alt_pkg::uvec_state_t state_reg, state_next;

    logic [35:0] mx_reg, my_reg, m_max, abs_x, abs_y;
    logic        sx_reg, sy_reg;
    logic [61:0] sqx_reg, sqy_reg;
    logic [63:0] rad_reg;
    logic [35:0] rem_reg, rem_t, trial;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic signed [31:0] ox_reg, oy_reg;
    logic        div_start, div_done, div_done_y;
    logic [63:0] num_x, num_y;
    logic [32:0] q_x, q_y;

    assign abs_x = in_x[35] ? 36'(-in_x) : 36'(in_x);
    assign abs_y = in_y[35] ? 36'(-in_y) : 36'(in_y);
    assign m_max = (mx_reg > my_reg) ? mx_reg : my_reg;
    assign rem_t = {rem_reg[33:0], rad_reg[63:62]};
    assign trial = {2'b0, root_reg, 2'b01};
    assign num_x = {mx_reg[33:0], 30'b0} + 64'(root_reg[31:1]);
    assign num_y = {my_reg[33:0], 30'b0} + 64'(root_reg[31:1]);
    assign out_x = ox_reg;
    assign out_y = oy_reg;

    alt_div u_div_x (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(num_x),
        .den({3'b0, root_reg}), .done(div_done), .quo(q_x)
    );
    alt_div u_div_y (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(num_y),
        .den({3'b0, root_reg}), .done(div_done_y), .quo(q_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= alt_pkg::U_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        done       = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            alt_pkg::U_IDLE: begin
                if (start) begin
                    state_next = (in_x == '0 && in_y == '0) ? alt_pkg::U_DONE
                                                            : alt_pkg::U_NORM;
                end
            end
            alt_pkg::U_NORM: begin
                if (m_max[35:31] == '0 && m_max[30]) begin
                    state_next = alt_pkg::U_SQ;
                end
            end
            alt_pkg::U_SQ:  state_next = alt_pkg::U_SUM;
            alt_pkg::U_SUM: state_next = alt_pkg::U_ROOT;
            alt_pkg::U_ROOT: begin
                if (cnt_reg == 5'(alt_pkg::ROOT_STEPS - 1)) begin
                    state_next = alt_pkg::U_DIVGO;
                end
            end
            alt_pkg::U_DIVGO: begin
                div_start  = 1'b1;
                state_next = alt_pkg::U_DIVWAIT;
            end
            alt_pkg::U_DIVWAIT: begin
                if (div_done) begin
                    state_next = alt_pkg::U_DONE;
                end
            end
            alt_pkg::U_DONE: begin
                done       = 1'b1;
                state_next = alt_pkg::U_IDLE;
            end
            default: state_next = alt_pkg::U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            alt_pkg::U_IDLE: begin
                mx_reg <= abs_x;
                my_reg <= abs_y;
                sx_reg <= in_x[35];
                sy_reg <= in_y[35];
                ox_reg <= '0;
                oy_reg <= '0;
            end
            alt_pkg::U_NORM: begin
                // right shifts truncate each magnitude on its own
                if (m_max[35:31] != '0) begin
                    mx_reg <= mx_reg >> 1;
                    my_reg <= my_reg >> 1;
                end else if (!m_max[30]) begin
                    mx_reg <= mx_reg << 1;
                    my_reg <= my_reg << 1;
                end
            end
            alt_pkg::U_SQ: begin
                sqx_reg <= mx_reg[30:0] * mx_reg[30:0];
                sqy_reg <= my_reg[30:0] * my_reg[30:0];
            end
            alt_pkg::U_SUM: begin
                rad_reg  <= 64'(sqx_reg) + 64'(sqy_reg);
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            alt_pkg::U_ROOT: begin
                rad_reg <= rad_reg << 2;
                cnt_reg <= cnt_reg + 1'b1;
                if (rem_t >= trial) begin
                    rem_reg  <= rem_t - trial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end else begin
                    rem_reg  <= rem_t;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            alt_pkg::U_DIVWAIT: begin
                if (div_done && div_done_y) begin
                    ox_reg <= sx_reg ? -$signed(q_x[31:0]) : $signed(q_x[31:0]);
                    oy_reg <= sy_reg ? -$signed(q_y[31:0]) : $signed(q_y[31:0]);
                end
            end
            default: ;
        endcase
    end
endmodule

/* hw/rtl/alt_engine.sv */
// alt_engine: back end, builds the quad and fringe vertices of one segment
// depends on alt_pkg, alt_uvec and alt_div
module alt_engine (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  alt_pkg::seg_t  q_seg,
    input  logic [30:0]    line_width,
    input  logic [30:0]    border_width,
    input  logic [31:0]    fill_color,
    output logic           set_valid,
    input  logic           set_ready,
    output alt_pkg::vset_t set_data
);
    alt_pkg::eng_state_t state_reg, state_next;

    alt_pkg::seg_t seg_reg;
    logic signed [31:0] ux_reg, uy_reg;
    logic signed [35:0] dxs_reg, dys_reg;
    logic signed [35:0] px_reg [4];
    logic signed [35:0] py_reg [4];
    logic signed [35:0] ex_reg [4];
    logic signed [35:0] ey_reg [4];
    logic signed [31:0] nx_reg [4];
    logic signed [31:0] ny_reg [4];
    logic signed [32:0] sumx_reg [4];
    logic signed [32:0] sumy_reg [4];
    logic [1:0]  idx_reg, idx_prev;
    logic [63:0] s_reg;
    logic [31:0] sc_reg;
    logic signed [33:0] mx_reg, my_reg;
    logic signed [39:0] ox_reg;
    logic [31:0] fx_reg [4];
    logic [31:0] fy_reg [4];
    logic [65:0] prod_reg;
    logic        neg_reg;

    logic signed [33:0] mul_a, mul_b;
    logic [32:0] mag_a, mag_b;
    logic signed [32:0] rr;
    logic [30:0] r_val;
    logic        uv_start, uv_done;
    logic signed [35:0] uv_in_x, uv_in_y;
    logic signed [31:0] uv_x, uv_y;
    logic        div_start, div_done;
    logic [32:0] div_q;
    logic signed [39:0] rnd29, rnd30;
    logic signed [35:0] ax, ay, bx, by;

    function automatic logic signed [39:0] round_prod(input logic [65:0] p, input logic neg,
                                                       input logic sh30);
        logic [66:0] t;
        logic [39:0] m;
        t = sh30 ? (({1'b0, p} + (67'd1 << 29)) >> 30)
                 : (({1'b0, p} + (67'd1 << 28)) >> 29);
        m = t[39:0];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [33:0] clamp_mx(input logic signed [39:0] v);
        if (v > alt_pkg::MX_LIMIT) begin
            return alt_pkg::MX_LIMIT[33:0];
        end else if (v < -alt_pkg::MX_LIMIT) begin
            return 34'(-alt_pkg::MX_LIMIT);
        end
        return v[33:0];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    assign rr    = $signed({2'b0, line_width}) - alt_pkg::WIDTH_ONE;
    assign r_val = (rr < alt_pkg::R_LOW_LIMIT) ? alt_pkg::R_MIN : rr[31:1];
    assign mag_a = mul_a[33] ? 33'(-mul_a) : mul_a[32:0];
    assign mag_b = mul_b[33] ? 33'(-mul_b) : mul_b[32:0];
    assign rnd29 = round_prod(prod_reg, neg_reg, 1'b0);
    assign rnd30 = round_prod(prod_reg, neg_reg, 1'b1);
    assign idx_prev = idx_reg - 2'd1;
    assign ax = 36'(seg_reg.a_x);
    assign ay = 36'(seg_reg.a_y);
    assign bx = 36'(seg_reg.b_x);
    assign by = 36'(seg_reg.b_y);
    assign uv_in_x = (state_reg == alt_pkg::E_IDLE) ? 36'(q_seg.d_x) : ex_reg[idx_reg];
    assign uv_in_y = (state_reg == alt_pkg::E_IDLE) ? 36'(q_seg.d_y) : ey_reg[idx_reg];

    alt_uvec u_uvec (
        .aclk(aclk), .aresetn(aresetn), .start(uv_start), .in_x(uv_in_x), .in_y(uv_in_y),
        .done(uv_done), .out_x(uv_x), .out_y(uv_y)
    );

    alt_div u_scale_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num((64'd1 << 60) + 64'(s_reg[63:31])), .den({1'b0, s_reg[63:30]}),
        .done(div_done), .quo(div_q)
    );

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            set_data.vert_x[k]     = sat32(40'(px_reg[k]));
            set_data.vert_y[k]     = sat32(40'(py_reg[k]));
            set_data.vert_x[k + 4] = fx_reg[k];
            set_data.vert_y[k + 4] = fy_reg[k];
        end
        set_data.color = fill_color;
        set_data.base  = seg_reg.vertex_base;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mag_a * mag_b;
        neg_reg  <= mul_a[33] ^ mul_b[33];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= alt_pkg::E_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        q_ready    = 1'b0;
        uv_start   = 1'b0;
        div_start  = 1'b0;
        set_valid  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            alt_pkg::E_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    uv_start   = 1'b1;
                    state_next = alt_pkg::E_DIR;
                end
            end
            alt_pkg::E_DIR: begin
                if (uv_done) begin
                    state_next = alt_pkg::E_RX;
                end
            end
            alt_pkg::E_RX: begin
                mul_a      = 34'(ux_reg);
                mul_b      = {3'b0, r_val};
                state_next = alt_pkg::E_RY;
            end
            alt_pkg::E_RY: begin
                mul_a      = 34'(uy_reg);
                mul_b      = {3'b0, r_val};
                state_next = alt_pkg::E_DYS;
            end
            alt_pkg::E_DYS:   state_next = alt_pkg::E_PTS;
            alt_pkg::E_PTS:   state_next = alt_pkg::E_EDGES;
            alt_pkg::E_EDGES: state_next = alt_pkg::E_EDGE_GO;
            alt_pkg::E_EDGE_GO: begin
                uv_start   = 1'b1;
                state_next = alt_pkg::E_EDGE_WAIT;
            end
            alt_pkg::E_EDGE_WAIT: begin
                if (uv_done) begin
                    state_next = (idx_reg == 2'd3) ? alt_pkg::E_F_PREP : alt_pkg::E_EDGE_GO;
                end
            end
            alt_pkg::E_F_PREP: state_next = alt_pkg::E_F_SQX;
            alt_pkg::E_F_SQX: begin
                mul_a      = 34'(sumx_reg[idx_reg]);
                mul_b      = 34'(sumx_reg[idx_reg]);
                state_next = alt_pkg::E_F_SQY;
            end
            alt_pkg::E_F_SQY: begin
                mul_a      = 34'(sumy_reg[idx_reg]);
                mul_b      = 34'(sumy_reg[idx_reg]);
                state_next = alt_pkg::E_F_S;
            end
            alt_pkg::E_F_S: state_next = alt_pkg::E_F_CLASS;
            alt_pkg::E_F_CLASS: begin
                if (s_reg > alt_pkg::CAP_THRESH) begin
                    div_start  = 1'b1;
                    state_next = alt_pkg::E_F_DIV;
                end else begin
                    state_next = alt_pkg::E_F_MX;
                end
            end
            alt_pkg::E_F_DIV: begin
                if (div_done) begin
                    state_next = alt_pkg::E_F_MX;
                end
            end
            alt_pkg::E_F_MX: begin
                mul_a      = 34'(sumx_reg[idx_reg]);
                mul_b      = {2'b0, sc_reg};
                state_next = alt_pkg::E_F_MY;
            end
            alt_pkg::E_F_MY: begin
                mul_a      = 34'(sumy_reg[idx_reg]);
                mul_b      = {2'b0, sc_reg};
                state_next = alt_pkg::E_F_OX;
            end
            alt_pkg::E_F_OX: begin
                mul_a      = mx_reg;
                mul_b      = {3'b0, border_width};
                state_next = alt_pkg::E_F_OY;
            end
            alt_pkg::E_F_OY: begin
                mul_a      = my_reg;
                mul_b      = {3'b0, border_width};
                state_next = alt_pkg::E_F_ST;
            end
            alt_pkg::E_F_ST: begin
                state_next = (idx_reg == 2'd3) ? alt_pkg::E_HAND : alt_pkg::E_F_SQX;
            end
            alt_pkg::E_HAND: begin
                set_valid = 1'b1;
                if (set_ready) begin
                    state_next = alt_pkg::E_IDLE;
                end
            end
            default: state_next = alt_pkg::E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            alt_pkg::E_IDLE: begin
                seg_reg <= q_seg;
            end
            alt_pkg::E_DIR: begin
                ux_reg <= uv_x;
                uy_reg <= uv_y;
            end
            alt_pkg::E_RY: begin
                dxs_reg <= rnd30[35:0];
            end
            alt_pkg::E_DYS: begin
                dys_reg <= rnd30[35:0];
            end
            alt_pkg::E_PTS: begin
                // quad corners, normal is (dys, -dxs)
                px_reg[0] <= ax - dxs_reg - dys_reg;
                py_reg[0] <= ay - dys_reg + dxs_reg;
                px_reg[1] <= ax - dxs_reg + dys_reg;
                py_reg[1] <= ay - dys_reg - dxs_reg;
                px_reg[2] <= bx + dxs_reg + dys_reg;
                py_reg[2] <= by + dys_reg - dxs_reg;
                px_reg[3] <= bx + dxs_reg - dys_reg;
                py_reg[3] <= by + dys_reg + dxs_reg;
                idx_reg   <= '0;
            end
            alt_pkg::E_EDGES: begin
                for (int k = 0; k < 4; k++) begin
                    ex_reg[k] <= px_reg[k] - px_reg[(k + 3) % 4];
                    ey_reg[k] <= py_reg[k] - py_reg[(k + 3) % 4];
                end
            end
            alt_pkg::E_EDGE_WAIT: begin
                if (uv_done) begin
                    nx_reg[idx_prev] <= uv_y;
                    ny_reg[idx_prev] <= -uv_x;
                    idx_reg          <= idx_reg + 2'd1;
                end
            end
            alt_pkg::E_F_PREP: begin
                for (int k = 0; k < 4; k++) begin
                    sumx_reg[k] <= 33'(nx_reg[(k + 3) % 4]) + 33'(nx_reg[k]);
                    sumy_reg[k] <= 33'(ny_reg[(k + 3) % 4]) + 33'(ny_reg[k]);
                end
            end
            alt_pkg::E_F_SQY: begin
                s_reg <= prod_reg[63:0];
            end
            alt_pkg::E_F_S: begin
                s_reg <= s_reg + prod_reg[63:0];
            end
            alt_pkg::E_F_CLASS: begin
                // tiny averaged normal stays unscaled, short one takes the cap
                if (s_reg <= alt_pkg::MAG_THRESH) begin
                    sc_reg <= alt_pkg::SCALE_ONE;
                end else if (s_reg <= alt_pkg::CAP_THRESH) begin
                    sc_reg <= alt_pkg::SCALE_CAP;
                end
            end
            alt_pkg::E_F_DIV: begin
                if (div_done) begin
                    sc_reg <= (div_q > {1'b0, alt_pkg::SCALE_CAP}) ? alt_pkg::SCALE_CAP
                                                                   : div_q[31:0];
                end
            end
            alt_pkg::E_F_MY: begin
                mx_reg <= clamp_mx(rnd29);
            end
            alt_pkg::E_F_OX: begin
                my_reg <= clamp_mx(rnd29);
            end
            alt_pkg::E_F_OY: begin
                ox_reg <= rnd30;
            end
            alt_pkg::E_F_ST: begin
                fx_reg[idx_reg] <= sat32(40'(px_reg[idx_reg]) + ox_reg);
                fy_reg[idx_reg] <= sat32(40'(py_reg[idx_reg]) + rnd30);
                idx_reg         <= idx_reg + 2'd1;
            end
            default: ;
        endcase
    end
endmodule

/* hw/rtl/alt_emit.sv */
// alt_emit: output stage, streams eight vertices and ten triangles per segment
// depends on alt_pkg
module alt_emit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           set_valid,
    output logic           set_ready,
    input  alt_pkg::vset_t set_data,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [191:0]   m_tdata,
    output logic [0:0]     m_tuser,
    output logic           m_tlast
);
    alt_pkg::vset_t set_reg;
    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic        fire, at_last, is_tri;
    logic [2:0]  o0, o1, o2;
    logic [31:0] vx, vy, vc, i0, i1, i2;

    assign fire      = m_tvalid & m_tready;
    assign at_last   = (cnt_reg == 5'(alt_pkg::NUM_RESULTS - 1));
    assign set_ready = !busy_reg || (fire && at_last);
    assign m_tvalid  = busy_reg;
    assign is_tri    = (cnt_reg >= 5'(alt_pkg::NUM_VERTS));

    // vertex offsets of each triangle: fringe strip pairs, then the quad
    always_comb begin
        case (cnt_reg)
            5'd8:    {o0, o1, o2} = {3'd0, 3'd3, 3'd7};
            5'd9:    {o0, o1, o2} = {3'd7, 3'd4, 3'd0};
            5'd10:   {o0, o1, o2} = {3'd1, 3'd0, 3'd4};
            5'd11:   {o0, o1, o2} = {3'd4, 3'd5, 3'd1};
            5'd12:   {o0, o1, o2} = {3'd2, 3'd1, 3'd5};
            5'd13:   {o0, o1, o2} = {3'd5, 3'd6, 3'd2};
            5'd14:   {o0, o1, o2} = {3'd3, 3'd2, 3'd6};
            5'd15:   {o0, o1, o2} = {3'd6, 3'd7, 3'd3};
            5'd16:   {o0, o1, o2} = {3'd0, 3'd1, 3'd2};
            5'd17:   {o0, o1, o2} = {3'd0, 3'd2, 3'd3};
            default: {o0, o1, o2} = '0;
        endcase
        if (is_tri) begin
            vx = '0;
            vy = '0;
            vc = '0;
            i0 = set_reg.base + 32'(o0);
            i1 = set_reg.base + 32'(o1);
            i2 = set_reg.base + 32'(o2);
        end else begin
            vx = set_reg.vert_x[cnt_reg[2:0]];
            vy = set_reg.vert_y[cnt_reg[2:0]];
            vc = cnt_reg[2] ? (set_reg.color & 32'h00FF_FFFF) : set_reg.color;
            i0 = '0;
            i1 = '0;
            i2 = '0;
        end
    end

    assign m_tdata    = {i2, i1, i0, vc, vy, vx};
    assign m_tuser[0] = is_tri ? alt_pkg::KIND_TRIANGLE : alt_pkg::KIND_VERTEX;
    assign m_tlast    = at_last;

    always_ff @(posedge aclk) begin
        if (set_valid && set_ready) begin
            set_reg <= set_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (set_valid && set_ready) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (fire) begin
            if (at_last) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end
endmodule

/* hw/rtl/antialiased_line_tessellator.sv */
// antialiased_line_tessellator: top level, register port and the front/back/output chain
// depends on alt_pkg, alt_front, alt_engine, alt_emit (and through them alt_uvec, alt_div)
//
// usage
//  - input stream s_*: one transaction per line segment, endpoints a and b in Q16.16
//    plus the index of the first of its eight output vertices
//  - output stream m_*: eighteen transactions per segment, four quad corners in the
//    fill color, four fringe vertices with alpha cleared, then ten triangles;
//    m_tuser marks triangles, m_tlast marks the eighteenth transaction
//  - registers line_width (0x0), border_width (0x4) and fill_color (0x8) on the apb
//    port; write them only while no segment is in flight
//  - each vertex set is built by five passes of the shared unit-vector unit (normalize
//    shifts, a one-bit-per-cycle square root and divider) and by a scale divide at each
//    fringe corner whose squared normal sum exceeds the cap threshold
//  - the queue takes further segments while the back end works, and the back end
//    builds the next vertex set while the output stage still streams the last one
//  - reset clears the queue, the sequencers and the output stage and restores the
//    register defaults; a stalled receiver holds the current transaction unchanged
module antialiased_line_tessellator #(
    parameter int QUEUE_DEPTH = alt_pkg::QUEUE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // apb register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [alt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // segment input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [159:0]                   s_tdata,  // a_x, a_y, b_x, b_y, vertex_base
    // result output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [191:0]                   m_tdata,  // vert_x, vert_y, vert_color,
                                                     // index0, index1, index2
    output logic [0:0]                     m_tuser,  // kind
    output logic                           m_tlast
);
    logic [30:0] line_width_reg, border_width_reg;
    logic [31:0] fill_color_reg;
    logic        cfg_write;
    logic [1:0]  reg_sel;

    logic           q_valid, q_ready;
    alt_pkg::seg_t  q_seg;
    logic           set_valid, set_ready;
    alt_pkg::vset_t set_data;

    // register access, always ready
    assign pready    = 1'b1;
    assign reg_sel   = paddr[3:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        case (reg_sel)
            alt_pkg::REG_LINE_WIDTH:   prdata = {1'b0, line_width_reg};
            alt_pkg::REG_BORDER_WIDTH: prdata = {1'b0, border_width_reg};
            alt_pkg::REG_FILL_COLOR:   prdata = fill_color_reg;
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= alt_pkg::LINE_WIDTH_RST;
            border_width_reg <= alt_pkg::BORDER_WIDTH_RST;
            fill_color_reg   <= alt_pkg::FILL_COLOR_RST;
        end else if (cfg_write) begin
            case (reg_sel)
                alt_pkg::REG_LINE_WIDTH:   line_width_reg   <= pwdata[30:0];
                alt_pkg::REG_BORDER_WIDTH: border_width_reg <= pwdata[30:0];
                alt_pkg::REG_FILL_COLOR:   fill_color_reg   <= pwdata;
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // front: unpack and queue segments
    alt_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_seg(q_seg)
    );

    // back: quad, edge normals and fringe offsets
    alt_engine u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_seg(q_seg),
        .line_width(line_width_reg), .border_width(border_width_reg),
        .fill_color(fill_color_reg),
        .set_valid(set_valid), .set_ready(set_ready), .set_data(set_data)
    );

    // output stage: vertices then triangles
    alt_emit u_emit (
        .aclk(aclk), .aresetn(aresetn),
        .set_valid(set_valid), .set_ready(set_ready), .set_data(set_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );
endmodule

/* verif/testbench.sv */
// testbench: self-checking bench for the antialiased line tessellator
// depends on alt_pkg and antialiased_line_tessellator; drives segments, checks all 18 outputs
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [alt_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [159:0] s_tdata = '0;   // a_x, a_y, b_x, b_y, vertex_base
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [191:0] m_tdata;        // vert_x, vert_y, vert_color, index0, index1, index2
    logic [0:0] m_tuser;          // kind
    logic m_tlast;

    // one output transaction as the predictor sees it
    typedef struct {
        logic        kind;
        logic [31:0] vx, vy, col, i0, i1, i2;
        logic        lst;
    } piece_t;

    piece_t pending_pieces[$];
    int errors = 0;
    int hold_off = 0;             // long receiver stall, cycles
    logic [30:0] cur_width = alt_pkg::LINE_WIDTH_RST;
    logic [30:0] cur_border = alt_pkg::BORDER_WIDTH_RST;
    logic [31:0] cur_color = alt_pkg::FILL_COLOR_RST;

    antialiased_line_tessellator uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #20ms;
        $display("testbench: done, errors");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic longint unsigned mag_of(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v -= res + bit_w;
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    // round(a*b/2^sh), halves away from zero
    function automatic longint mul_rnd(longint a, longint b, int sh);
        longint unsigned p;
        p = mag_of(a) * mag_of(b);
        p = (p + (64'd1 << (sh - 1))) >> sh;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    // Q2.30 unit vector, zero for zero input
    task automatic unit_dir(input longint dx, input longint dy, output longint ux,
                            output longint uy);
        longint unsigned mx, my, m, len, qx, qy;
        mx = mag_of(dx);
        my = mag_of(dy);
        if (mx == 0 && my == 0) begin
            ux = 0;
            uy = 0;
            return;
        end
        m = mx > my ? mx : my;
        while (m >= (64'd1 << 31)) begin mx >>= 1; my >>= 1; m >>= 1; end
        while (m < (64'd1 << 30)) begin mx <<= 1; my <<= 1; m <<= 1; end
        len = int_root(mx * mx + my * my);
        qx = ((mx << 30) + len / 2) / len;
        qy = ((my << 30) + len / 2) / len;
        ux = dx < 0 ? -longint'(qx) : longint'(qx);
        uy = dy < 0 ? -longint'(qy) : longint'(qy);
    endtask

    function automatic logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic longint clamp_mag(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // append one expectation at the tail
    task automatic queue_piece(input piece_t pc);
        pending_pieces.insert(pending_pieces.size(), pc);
    endtask

    task automatic tessellate(input logic [159:0] seg);
        longint ax, ay, bx, by, ux, uy, rr, r, dxs, dys, nxs, nys, ex, ey;
        longint sx, sy, sc, mx, my;
        longint px[4], py[4], nx[4], ny[4];
        longint unsigned s_sq, sr;
        logic [31:0] vb, ii, jj;
        piece_t pc;
        int j;
        ax = longint'($signed(seg[31:0]));
        ay = longint'($signed(seg[63:32]));
        bx = longint'($signed(seg[95:64]));
        by = longint'($signed(seg[127:96]));
        vb = seg[159:128];
        unit_dir(bx - ax, by - ay, ux, uy);
        rr = longint'(cur_width) - 65536;
        r = (rr < 2 * longint'(alt_pkg::R_MIN)) ? longint'(alt_pkg::R_MIN) : rr / 2;
        dxs = mul_rnd(ux, r, 30);
        dys = mul_rnd(uy, r, 30);
        nxs = dys;
        nys = -dxs;
        px[0] = ax - dxs - nxs; py[0] = ay - dys - nys;
        px[1] = ax - dxs + nxs; py[1] = ay - dys + nys;
        px[2] = bx + dxs + nxs; py[2] = by + dys + nys;
        px[3] = bx + dxs - nxs; py[3] = by + dys - nys;
        for (int i = 0; i < 4; i++) begin
            j = (i + 3) & 3;
            unit_dir(px[i] - px[j], py[i] - py[j], ex, ey);
            nx[j] = ey;
            ny[j] = -ex;
        end
        // inner quad corners
        for (int i = 0; i < 4; i++) begin
            pc = '{alt_pkg::KIND_VERTEX, clip32(px[i]), clip32(py[i]), cur_color,
                   0, 0, 0, 1'b0};
            queue_piece(pc);
        end
        // fringe corners pushed out along the mitered normal
        for (int i = 0; i < 4; i++) begin
            j = (i + 3) & 3;
            sx = nx[j] + nx[i];
            sy = ny[j] + ny[i];
            s_sq = mag_of(sx) * mag_of(sx) + mag_of(sy) * mag_of(sy);
            if (s_sq <= alt_pkg::MAG_THRESH) sc = longint'(alt_pkg::SCALE_ONE);
            else if (s_sq <= alt_pkg::CAP_THRESH) sc = longint'(alt_pkg::SCALE_CAP);
            else begin
                sr = s_sq >> 30;
                sc = longint'(((64'd1 << 60) + sr / 2) / sr);
                if (sc > longint'(alt_pkg::SCALE_CAP)) sc = longint'(alt_pkg::SCALE_CAP);
            end
            mx = clamp_mag(mul_rnd(sx, sc, 29), 64'sd4 << 30);
            my = clamp_mag(mul_rnd(sy, sc, 29), 64'sd4 << 30);
            pc = '{alt_pkg::KIND_VERTEX,
                   clip32(px[i] + mul_rnd(mx, longint'(cur_border), 30)),
                   clip32(py[i] + mul_rnd(my, longint'(cur_border), 30)),
                   cur_color & 32'h00FF_FFFF, 0, 0, 0, 1'b0};
            queue_piece(pc);
        end
        // fringe strip, two triangles per edge, indices wrap
        for (int i = 0; i < 4; i++) begin
            ii = i;
            jj = (i + 3) & 3;
            pc = '{alt_pkg::KIND_TRIANGLE, 0, 0, 0, vb + ii, vb + jj, vb + 4 + jj, 1'b0};
            queue_piece(pc);
            pc = '{alt_pkg::KIND_TRIANGLE, 0, 0, 0, vb + 4 + jj, vb + 4 + ii, vb + ii, 1'b0};
            queue_piece(pc);
        end
        pc = '{alt_pkg::KIND_TRIANGLE, 0, 0, 0, vb, vb + 1, vb + 2, 1'b0};
        queue_piece(pc);
        pc = '{alt_pkg::KIND_TRIANGLE, 0, 0, 0, vb, vb + 2, vb + 3, 1'b1};
        queue_piece(pc);
    endtask

    // ---------------- register writes ----------------
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            alt_pkg::REG_LINE_WIDTH:   cur_width = value[30:0];
            alt_pkg::REG_BORDER_WIDTH: cur_border = value[30:0];
            alt_pkg::REG_FILL_COLOR:   cur_color = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // wait for the block to drain, plus slack for the final stream
    task automatic drain();
        int guard;
        guard = 0;
        while (pending_pieces.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        if (guard >= 200000) begin
            $display("testbench: done, errors");
            $finish;
        end
        repeat (50) @(posedge aclk);
    endtask

    // ---------------- sender ----------------
    int burst_left = 0;

    task automatic send_seg(input logic [159:0] seg);
        int gap;
        // random gaps between bursts
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 6);
        end
        s_tvalid <= 1'b1;
        s_tdata <= seg;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tessellate(seg);
        burst_left--;
    endtask

    function automatic logic [159:0] pack_seg(logic [31:0] a_x, a_y, b_x, b_y, base);
        return {base, b_y, b_x, a_y, a_x};
    endfunction

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return 32'($signed($urandom_range(0, 200)) - 100) <<< 16;
        endcase
    endfunction

    // directed rows: endpoints and base, with extremes and degenerate segments
    typedef struct {
        logic [31:0] ax, ay, bx, by, base;
    } seg_row_t;

    seg_row_t directed_rows [11] = '{
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd0},
        '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd8},
        '{32'h0000_0000, 32'h0000_0000, 32'h000A_0000, 32'h0000_0000, 32'd16},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h000A_0000, 32'd24},
        '{32'h0005_0000, 32'h0005_0000, 32'hFFFB_0000, 32'hFFFB_0000, 32'd100},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFF8},
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFC},
        '{32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'd7},
        '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9, 32'h8765_4321, 32'hAAAA_AAAA},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555}
    };

    initial begin
        logic [159:0] seg;
        int mode;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // defaults after reset
        foreach (directed_rows[k])
            send_seg(pack_seg(directed_rows[k].ax, directed_rows[k].ay, directed_rows[k].bx,
                              directed_rows[k].by, directed_rows[k].base));
        s_tvalid <= 1'b0;
        drain();
        // extreme settings: thinnest line, no fringe from a border value with only the dropped top bit set, black
        reg_write(alt_pkg::REG_LINE_WIDTH, 32'h0000_0000);
        reg_write(alt_pkg::REG_BORDER_WIDTH, 32'h8000_0000);
        reg_write(alt_pkg::REG_FILL_COLOR, 32'h0000_0000);
        for (int k = 0; k < 4; k++) send_seg(pack_seg(rand_coord(1), rand_coord(1),
                                                     rand_coord(1), rand_coord(1), $urandom()));
        s_tvalid <= 1'b0;
        drain();
        // widest line and fringe
        reg_write(alt_pkg::REG_LINE_WIDTH, 32'hFFFF_FFFF);
        reg_write(alt_pkg::REG_BORDER_WIDTH, 32'h7FFF_FFFF);
        reg_write(alt_pkg::REG_FILL_COLOR, 32'h80FF_00FF);
        for (int k = 0; k < 4; k++) send_seg(pack_seg(rand_coord(k & 1), rand_coord(1),
                                                     rand_coord(2), rand_coord(0), $urandom()));
        s_tvalid <= 1'b0;
        drain();
        // random phases with random settings; long receiver stall in the first
        for (int ph = 0; ph < 5; ph++) begin
            reg_write(alt_pkg::REG_LINE_WIDTH, $urandom_range(0, 3) == 0 ? $urandom()
                                                    : $urandom_range(0, 20 << 16));
            reg_write(alt_pkg::REG_BORDER_WIDTH, $urandom_range(0, 3) == 0 ? $urandom()
                                                      : $urandom_range(0, 4 << 16));
            reg_write(alt_pkg::REG_FILL_COLOR, $urandom());
            if (ph == 0) hold_off = 3000;
            for (int k = 0; k < 40; k++) begin
                mode = $urandom_range(0, 2);
                seg = pack_seg(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                               rand_coord(mode), $urandom());
                if ($urandom_range(0, 9) == 0) seg[127:64] = seg[63:0];   // zero length
                send_seg(seg);
            end
            s_tvalid <= 1'b0;
            drain();
        end
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // ---------------- receiver ----------------
    // stall pattern: on/off stretches, plus one long hold-off
    initial begin
        int run;
        @(posedge aresetn);
        forever begin
            if (hold_off > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off) @(posedge aclk);
                hold_off = 0;
            end
            run = $urandom_range(1, 30);
            m_tready <= ($urandom_range(0, 2) != 0);
            repeat (run) @(posedge aclk);
        end
    end

    // compare every output transaction against the oldest expectation
    always @(posedge aclk) begin
        piece_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pieces.size() == 0) begin
                $display("%0t: unexpected transaction %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_pieces.pop_front();
                if (m_tuser[0] !== want.kind || m_tlast !== want.lst ||
                    m_tdata !== {want.i2, want.i1, want.i0, want.col, want.vy, want.vx}) begin
                    $display("%0t: mismatch expected kind %b last %b data %h", $time,
                             want.kind, want.lst,
                             {want.i2, want.i1, want.i0, want.col, want.vy, want.vx});
                    $display("%0t:          actual   kind %b last %b data %h", $time,
                             m_tuser[0], m_tlast, m_tdata);
                    errors++;
                end
            end
        end
    end
endmodule
